// ----- rtl/core/jpt_pkg.sv -----
// Shared types and constants for the joystick pan/tilt position block.
package jpt_pkg;

   localparam int unsigned AngleWidth = 8;
   localparam int unsigned AxisWidth  = 16;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   localparam logic [AngleWidth-1:0] ANGLE_MAX = 8'd180;
   localparam logic [AngleWidth-1:0] ANGLE_RESET = 8'd90;
   // One half in Q1.15, widened to the 17-bit signed domain of an inverted axis.
   localparam logic signed [AxisWidth:0] HALF_Q15 = 17'sd16384;
   localparam logic signed [AxisWidth:0] NEG_HALF_Q15 = -17'sd16384;
   localparam logic [AxisWidth:0] AXIS_OFFSET = 17'd32768;
   localparam logic [6:0] DEGREES_PER_HALF = 7'd90;

   typedef enum logic [1:0] {
      MODE_BUTTONS     = 2'd0,
      MODE_AXES        = 2'd1,
      MODE_AXIS_BUTTON = 2'd2,
      MODE_RESERVED    = 2'd3
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CONTROL_MODE   = 3'd0,
      CSR_RESET_PRESENT  = 3'd1,
      CSR_LOCK_IS_SWITCH = 3'd2,
      CSR_LOCK_START     = 3'd3,
      CSR_PAN_INVERT     = 3'd4,
      CSR_TILT_INVERT    = 3'd5,
      CSR_PAN_HOME       = 3'd6,
      CSR_TILT_HOME      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                         action;
      logic                         btn_pan_up;
      logic                         btn_pan_down;
      logic                         btn_tilt_up;
      logic                         btn_tilt_down;
      logic                         btn_reset;
      logic signed [AxisWidth-1:0]  axis_pan_value;
      logic signed [AxisWidth-1:0]  axis_tilt_value;
   } req_type;

   typedef struct packed {
      logic [AngleWidth-1:0] pan_out;
      logic [AngleWidth-1:0] tilt_out;
   } rsp_type;

   typedef struct packed {
      logic pan_up;
      logic pan_down;
      logic tilt_up;
      logic tilt_down;
      logic home;
   } buttons_type;

   // What one axis converter reports for a stick sample.
   typedef struct packed {
      logic [AngleWidth-1:0] angle;
      logic                  up;
      logic                  down;
   } axis_info_type;

endpackage

// ----- rtl/core/jpt_axis.sv -----
// Converts one stick axis into an absolute angle and up/down threshold flags.
module jpt_axis (
   input  logic signed [jpt_pkg::AxisWidth-1:0] value,
   input  logic                                 invert,
   output jpt_pkg::axis_info_type               info
);

   logic signed [jpt_pkg::AxisWidth:0] v;
   logic [jpt_pkg::AxisWidth:0]        u;
   logic [jpt_pkg::AxisWidth+6:0]      scaled;

   always_comb begin
      v = invert ? -{value[jpt_pkg::AxisWidth-1], value}
                 : {value[jpt_pkg::AxisWidth-1], value};
      // Offset into 0..65536, then (u * 90) / 32768.
      u = $unsigned(v) + jpt_pkg::AXIS_OFFSET;
      scaled = {6'd0, u} * {{(jpt_pkg::AxisWidth){1'b0}}, jpt_pkg::DEGREES_PER_HALF};
      info.angle = scaled[jpt_pkg::AxisWidth+6:jpt_pkg::AxisWidth-1];
      info.up = v > jpt_pkg::HALF_Q15;
      info.down = v < jpt_pkg::NEG_HALF_Q15;
   end

endmodule

// ----- rtl/core/joystick_pan_tilt_position.sv -----
// Top level: pan/tilt angle keeper driven by joystick samples and ticks.
//
// The req_ channel carries one item per accepted handshake: a joystick sample
// (action 0) or a periodic tick (action 1). The rsp_ channel returns the pan
// and tilt angles whenever an item causes an output: a tick in any mode but
// axis mode, or an unlocked sample in axis mode. Other items only update state.
// The csr_ port writes configuration registers by index; write it only while
// no items are in flight.
// An accepted item's result goes to the result register, or to the skid register
// if that one is held. One item is accepted every cycle while req_stall is low;
// all the work is one combinational pass from the request ports into the state and result registers.
// A result register and a one-entry skid register sit on the output, so
// req_stall rises only when both hold results that the receiver has not taken.
// Reset puts both angles at 90, releases all buttons, clears the lock
// bookkeeping and restores the configuration defaults.
module joystick_pan_tilt_position (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  jpt_pkg::req_type                       req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output jpt_pkg::rsp_type                       rsp_payload,
   input  logic                                   csr_we,
   input  logic [jpt_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [jpt_pkg::CsrDataWidth-1:0]       csr_wdata
);

   // Configuration registers.
   logic [1:0] mode_ff;
   logic       home_present_ff, lock_switch_ff, lock_start_ff;
   logic       pan_invert_ff, tilt_invert_ff;
   logic [jpt_pkg::AngleWidth-1:0] pan_home_ff, tilt_home_ff;

   // Block state.
   logic [jpt_pkg::AngleWidth-1:0] pan_ff, pan_in, tilt_ff, tilt_in;
   jpt_pkg::buttons_type held_ff, held_in;
   logic lock_toggled_ff, lock_toggled_in, release_pending_ff, release_pending_in;

   // Output stages.
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   jpt_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;

   jpt_pkg::axis_info_type pan_info, tilt_info;
   logic accept, produce, out_take;
   logic [jpt_pkg::AngleWidth-1:0] pan_home_clamped, tilt_home_clamped;
   jpt_pkg::buttons_type flags;

   jpt_axis u_pan_axis (
      .value  (req_payload.axis_pan_value),
      .invert (pan_invert_ff),
      .info   (pan_info)
   );

   jpt_axis u_tilt_axis (
      .value  (req_payload.axis_tilt_value),
      .invert (tilt_invert_ff),
      .info   (tilt_info)
   );

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   assign pan_home_clamped = (pan_home_ff > jpt_pkg::ANGLE_MAX) ? jpt_pkg::ANGLE_MAX
                                                                : pan_home_ff;
   assign tilt_home_clamped = (tilt_home_ff > jpt_pkg::ANGLE_MAX) ? jpt_pkg::ANGLE_MAX
                                                                  : tilt_home_ff;

   always_comb begin
      pan_in = pan_ff;
      tilt_in = tilt_ff;
      held_in = held_ff;
      lock_toggled_in = lock_toggled_ff;
      release_pending_in = release_pending_ff;
      produce = 1'b0;
      flags = '0;

      if (accept) begin
         if (req_payload.action) begin
            if (mode_ff != jpt_pkg::MODE_AXES) begin
               // Increase is applied before decrease when both are held.
               if (held_ff.tilt_up && tilt_in < jpt_pkg::ANGLE_MAX) begin
                  tilt_in = tilt_in + 8'd1;
               end
               if (held_ff.tilt_down && tilt_in != 8'd0) begin
                  tilt_in = tilt_in - 8'd1;
               end
               if (held_ff.pan_up && pan_in < jpt_pkg::ANGLE_MAX) begin
                  pan_in = pan_in + 8'd1;
               end
               if (held_ff.pan_down && pan_in != 8'd0) begin
                  pan_in = pan_in - 8'd1;
               end
               if (held_ff.home && home_present_ff) begin
                  pan_in = pan_home_clamped;
                  tilt_in = tilt_home_clamped;
               end
               produce = 1'b1;
            end
         end else if (mode_ff == jpt_pkg::MODE_AXES) begin
            produce = 1'b1;
            if (home_present_ff) begin
               if (lock_switch_ff) begin
                  if (req_payload.btn_reset ^ lock_start_ff) begin
                     produce = 1'b0;
                  end
               end else begin
                  // The toggle lock flips when the button is released.
                  if (req_payload.btn_reset) begin
                     release_pending_in = 1'b1;
                  end else if (release_pending_ff) begin
                     release_pending_in = 1'b0;
                     lock_toggled_in = ~lock_toggled_ff;
                  end
                  if (lock_start_ff ^ lock_toggled_in) begin
                     produce = 1'b0;
                  end
               end
            end
            if (produce) begin
               pan_in = pan_info.angle;
               tilt_in = tilt_info.angle;
            end
         end else begin
            if (mode_ff == jpt_pkg::MODE_AXIS_BUTTON) begin
               flags.pan_up = pan_info.up;
               flags.pan_down = pan_info.down;
               flags.tilt_up = tilt_info.up;
               flags.tilt_down = tilt_info.down;
            end else begin
               flags.pan_up = req_payload.btn_pan_up;
               flags.pan_down = req_payload.btn_pan_down;
               flags.tilt_up = req_payload.btn_tilt_up;
               flags.tilt_down = req_payload.btn_tilt_down;
            end
            flags.home = home_present_ff ? req_payload.btn_reset : held_ff.home;
            held_in = flags;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = produce;
            out_in.pan_out = pan_in;
            out_in.tilt_out = tilt_in;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in.pan_out = pan_in;
         skid_in.tilt_out = tilt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jpt_pkg::MODE_BUTTONS;
         home_present_ff <= 1'b0;
         lock_switch_ff <= 1'b0;
         lock_start_ff <= 1'b0;
         pan_invert_ff <= 1'b0;
         tilt_invert_ff <= 1'b0;
         pan_home_ff <= jpt_pkg::ANGLE_RESET;
         tilt_home_ff <= jpt_pkg::ANGLE_RESET;
      end else if (csr_we) begin
         case (jpt_pkg::csr_index_type'(csr_index))
            jpt_pkg::CSR_CONTROL_MODE:   mode_ff <= csr_wdata[1:0];
            jpt_pkg::CSR_RESET_PRESENT:  home_present_ff <= csr_wdata[0];
            jpt_pkg::CSR_LOCK_IS_SWITCH: lock_switch_ff <= csr_wdata[0];
            jpt_pkg::CSR_LOCK_START:     lock_start_ff <= csr_wdata[0];
            jpt_pkg::CSR_PAN_INVERT:     pan_invert_ff <= csr_wdata[0];
            jpt_pkg::CSR_TILT_INVERT:    tilt_invert_ff <= csr_wdata[0];
            jpt_pkg::CSR_PAN_HOME:       pan_home_ff <= csr_wdata;
            jpt_pkg::CSR_TILT_HOME:      tilt_home_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff <= jpt_pkg::ANGLE_RESET;
         tilt_ff <= jpt_pkg::ANGLE_RESET;
         held_ff <= '0;
         lock_toggled_ff <= 1'b0;
         release_pending_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pan_ff <= pan_in;
         tilt_ff <= tilt_in;
         held_ff <= held_in;
         lock_toggled_ff <= lock_toggled_in;
         release_pending_ff <= release_pending_in;
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- dv/joystick_pan_tilt_position_tb.sv -----
// Self-checking testbench for the joystick pan/tilt position keeper.
`timescale 1ns / 1ps

module joystick_pan_tilt_position_tb;

   localparam int LongHold = 200;

   // Tracks the expected pan/tilt angles and checks every returned item.
   class angle_keeper_model;
      jpt_pkg::mode_type     mode;
      bit                    home_present, lock_switch, lock_sense, pan_inv, tilt_inv;
      logic [7:0]            pan_home_reg, tilt_home_reg;
      logic [7:0]            pan_angle, tilt_angle;
      jpt_pkg::buttons_type  held;
      bit                    lock_flip, release_wait;
      jpt_pkg::rsp_type      pending_angles[$];
      int                    error_count, checked_count, item_count;

      function new();
         mode = jpt_pkg::MODE_BUTTONS;
         home_present = 0; lock_switch = 0; lock_sense = 0;
         pan_inv = 0; tilt_inv = 0;
         pan_home_reg = jpt_pkg::ANGLE_RESET; tilt_home_reg = jpt_pkg::ANGLE_RESET;
         pan_angle = jpt_pkg::ANGLE_RESET; tilt_angle = jpt_pkg::ANGLE_RESET;
         held = '0; lock_flip = 0; release_wait = 0;
         error_count = 0; checked_count = 0; item_count = 0;
      endfunction

      function void set_reg(jpt_pkg::csr_index_type idx, logic [7:0] v);
         case (idx)
            jpt_pkg::CSR_CONTROL_MODE:   mode = jpt_pkg::mode_type'(v[1:0]);
            jpt_pkg::CSR_RESET_PRESENT:  home_present = v[0];
            jpt_pkg::CSR_LOCK_IS_SWITCH: lock_switch = v[0];
            jpt_pkg::CSR_LOCK_START:     lock_sense = v[0];
            jpt_pkg::CSR_PAN_INVERT:     pan_inv = v[0];
            jpt_pkg::CSR_TILT_INVERT:    tilt_inv = v[0];
            jpt_pkg::CSR_PAN_HOME:       pan_home_reg = v;
            jpt_pkg::CSR_TILT_HOME:      tilt_home_reg = v;
            default: ;
         endcase
      endfunction

      function logic [7:0] clamp_angle(logic [7:0] h);
         return (h > jpt_pkg::ANGLE_MAX) ? jpt_pkg::ANGLE_MAX : h;
      endfunction

      function int axis_of(logic signed [15:0] raw, bit inv);
         int v;
         v = raw;
         if (inv) v = -v;
         return v;
      endfunction

      function logic [7:0] angle_of(int v);
         int scaled;
         scaled = ((v + 32768) * 90) >>> 15;
         return scaled[7:0];
      endfunction

      function void push_angles();
         jpt_pkg::rsp_type r;
         r.pan_out = pan_angle;
         r.tilt_out = tilt_angle;
         pending_angles.push_back(r);
      endfunction

      function void note_item(jpt_pkg::req_type it);
         int p, t;
         jpt_pkg::buttons_type flags;
         item_count++;
         if (it.action) begin
            if (mode == jpt_pkg::MODE_AXES) return;
            // Increase is applied before decrease when both are held.
            if (held.tilt_up && tilt_angle < jpt_pkg::ANGLE_MAX) tilt_angle = tilt_angle + 8'd1;
            if (held.tilt_down && tilt_angle > 0) tilt_angle = tilt_angle - 8'd1;
            if (held.pan_up && pan_angle < jpt_pkg::ANGLE_MAX) pan_angle = pan_angle + 8'd1;
            if (held.pan_down && pan_angle > 0) pan_angle = pan_angle - 8'd1;
            if (held.home && home_present) begin
               pan_angle = clamp_angle(pan_home_reg);
               tilt_angle = clamp_angle(tilt_home_reg);
            end
            push_angles();
            return;
         end
         p = axis_of(it.axis_pan_value, pan_inv);
         t = axis_of(it.axis_tilt_value, tilt_inv);
         if (mode == jpt_pkg::MODE_AXES) begin
            if (home_present) begin
               if (lock_switch) begin
                  if (it.btn_reset ^ lock_sense) return;
               end else begin
                  // The toggle lock flips when the button is let go.
                  if (it.btn_reset) begin
                     release_wait = 1;
                  end else if (release_wait) begin
                     release_wait = 0;
                     lock_flip = !lock_flip;
                  end
                  if (lock_sense ^ lock_flip) return;
               end
            end
            pan_angle = angle_of(p);
            tilt_angle = angle_of(t);
            push_angles();
            return;
         end
         flags = '0;
         if (mode == jpt_pkg::MODE_AXIS_BUTTON) begin
            if (p > jpt_pkg::HALF_Q15) flags.pan_up = 1;
            else if (p < jpt_pkg::NEG_HALF_Q15) flags.pan_down = 1;
            if (t > jpt_pkg::HALF_Q15) flags.tilt_up = 1;
            else if (t < jpt_pkg::NEG_HALF_Q15) flags.tilt_down = 1;
         end else begin
            flags.pan_up = it.btn_pan_up;
            flags.pan_down = it.btn_pan_down;
            flags.tilt_up = it.btn_tilt_up;
            flags.tilt_down = it.btn_tilt_down;
         end
         flags.home = home_present ? it.btn_reset : held.home;
         held = flags;
      endfunction

      function void check_angles(jpt_pkg::rsp_type got);
         jpt_pkg::rsp_type want;
         if (pending_angles.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, actual pan %0d tilt %0d",
                     $time, got.pan_out, got.tilt_out);
            return;
         end
         want = pending_angles.pop_front();
         checked_count++;
         if (got.pan_out !== want.pan_out) begin
            error_count++;
            $display("%0t: pan_out expected %0d actual %0d", $time, want.pan_out, got.pan_out);
         end
         if (got.tilt_out !== want.tilt_out) begin
            error_count++;
            $display("%0t: tilt_out expected %0d actual %0d", $time, want.tilt_out,
                     got.tilt_out);
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   jpt_pkg::req_type                      req_payload;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   jpt_pkg::rsp_type                      rsp_payload;
   logic                                  csr_we;
   logic [jpt_pkg::CsrIndexWidth-1:0]     csr_index;
   logic [jpt_pkg::CsrDataWidth-1:0]      csr_wdata;

   angle_keeper_model model;
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_request;
   int input_stall_cycles;
   int config_count;

   joystick_pan_tilt_position u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) model.check_angles(rsp_payload);
         if (req_valid && !req_stall) model.note_item(req_payload);
         if (req_valid && req_stall) input_stall_cycles++;
      end
   end

   // Receiver side: random stall bursts, plus one long hold on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(jpt_pkg::req_type it);
      int gap;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering items and waits until every expected result is back.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (model.pending_angles.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(jpt_pkg::csr_index_type idx, logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      model.set_reg(idx, v);
   endtask

   task automatic set_config(jpt_pkg::mode_type m, int pres, int sw, int st, int pi, int ti,
                             logic [7:0] ph, logic [7:0] th);
      settle();
      write_reg(jpt_pkg::CSR_CONTROL_MODE, {6'd0, m});
      write_reg(jpt_pkg::CSR_RESET_PRESENT, {7'd0, 1'(pres)});
      write_reg(jpt_pkg::CSR_LOCK_IS_SWITCH, {7'd0, 1'(sw)});
      write_reg(jpt_pkg::CSR_LOCK_START, {7'd0, 1'(st)});
      write_reg(jpt_pkg::CSR_PAN_INVERT, {7'd0, 1'(pi)});
      write_reg(jpt_pkg::CSR_TILT_INVERT, {7'd0, 1'(ti)});
      write_reg(jpt_pkg::CSR_PAN_HOME, ph);
      write_reg(jpt_pkg::CSR_TILT_HOME, th);
      config_count++;
   endtask

   function automatic jpt_pkg::req_type sample_item(int pu, int pd, int tu, int td, int home,
                                                    int pa, int ta);
      jpt_pkg::req_type it;
      it.action = 1'b0;
      it.btn_pan_up = 1'(pu);
      it.btn_pan_down = 1'(pd);
      it.btn_tilt_up = 1'(tu);
      it.btn_tilt_down = 1'(td);
      it.btn_reset = 1'(home);
      it.axis_pan_value = 16'(pa);
      it.axis_tilt_value = 16'(ta);
      return it;
   endfunction

   function automatic jpt_pkg::req_type tick_item();
      jpt_pkg::req_type it;
      it = '0;
      it.action = 1'b1;
      return it;
   endfunction

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd16384;
         3: return 16'sd16385;
         4: return -16'sd16384;
         5: return -16'sd16385;
         6: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_home();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return jpt_pkg::ANGLE_MAX;
         2: return 8'($urandom_range(181, 255));
         default: return 8'($urandom_range(0, 180));
      endcase
   endfunction

   function automatic jpt_pkg::req_type random_sample();
      jpt_pkg::req_type it;
      it = sample_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                       pick_axis(), pick_axis());
      return it;
   endfunction

   task automatic random_config();
      set_config(jpt_pkg::mode_type'($urandom_range(0, 3)), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), pick_home(), pick_home());
   endtask

   task automatic run_random_phase(int budget);
      int sent, k;
      jpt_pkg::req_type it;
      sent = 0;
      while (sent < budget) begin
         it = random_sample();
         if (model.mode == jpt_pkg::MODE_AXES) begin
            if ($urandom_range(0, 9) == 0) it.action = 1'b1;
            send_item(it);
            sent++;
         end else begin
            // A sample sets the held flags, then a run of ticks moves the angles.
            // Now and then the run is long enough to reach a limit.
            send_item(it);
            sent++;
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 6);
            repeat (k) begin
               it = random_sample();
               it.action = 1'b1;
               send_item(it);
               sent++;
            end
         end
      end
   endtask

   initial begin
      model = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = jpt_pkg::CSR_CONTROL_MODE;
      csr_wdata = '0;
      sender_gaps = 1;
      receiver_gaps = 1;
      hold_request = 0;
      input_stall_cycles = 0;
      config_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: held buttons, home button not wired.
      send_item(sample_item(1, 0, 0, 1, 1, 0, 0));
      send_item(tick_item());
      send_item(tick_item());
      send_item(sample_item(1, 1, 1, 1, 0, 0, 0));
      send_item(tick_item());

      // Absolute axes at their extremes; a tick gives nothing here.
      set_config(jpt_pkg::MODE_AXES, 0, 0, 0, 1, 0, jpt_pkg::ANGLE_RESET,
                 jpt_pkg::ANGLE_RESET);
      send_item(sample_item(0, 0, 0, 0, 0, -16'sd32768, -16'sd32768));
      send_item(tick_item());
      send_item(sample_item(0, 0, 0, 0, 1, 16'sd32767, 16'sd32767));
      send_item(sample_item(0, 0, 0, 0, 0, -16'sd32768, -16'sd32768));

      // Saturation at both ends, and a home angle above the range.
      set_config(jpt_pkg::MODE_BUTTONS, 1, 0, 0, 0, 0, 8'd200, 8'd0);
      send_item(sample_item(1, 0, 0, 1, 0, 0, 0));
      send_item(tick_item());
      send_item(sample_item(0, 0, 0, 0, 1, 0, 0));
      send_item(tick_item());

      // Axes used as buttons, on and just past the thresholds.
      set_config(jpt_pkg::MODE_AXIS_BUTTON, 1, 0, 0, 0, 0, 8'd0, jpt_pkg::ANGLE_MAX);
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd16385, -16'sd16385));
      send_item(tick_item());
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd16384, -16'sd16384));
      send_item(tick_item());
      send_item(sample_item(0, 0, 0, 0, 0, -16'sd16385, 16'sd16385));
      send_item(tick_item());

      // The reserved mode acts as button mode.
      set_config(jpt_pkg::MODE_RESERVED, 1, 0, 0, 0, 0, 8'd0, jpt_pkg::ANGLE_MAX);
      send_item(sample_item(0, 0, 1, 0, 1, 0, 0));
      send_item(tick_item());

      // Toggle lock: a press and its release lock, the next pair unlocks.
      set_config(jpt_pkg::MODE_AXES, 1, 0, 0, 0, 0, jpt_pkg::ANGLE_RESET,
                 jpt_pkg::ANGLE_RESET);
      send_item(sample_item(0, 0, 0, 0, 1, 16'sd1000, -16'sd1000));
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd2000, -16'sd2000));
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd3000, -16'sd3000));
      send_item(sample_item(0, 0, 0, 0, 1, 16'sd4000, -16'sd4000));
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd5000, -16'sd5000));

      // Switch lock with inverted sense.
      set_config(jpt_pkg::MODE_AXES, 1, 1, 1, 0, 1, jpt_pkg::ANGLE_RESET,
                 jpt_pkg::ANGLE_RESET);
      send_item(sample_item(0, 0, 0, 0, 0, 16'sd100, -16'sd32768));
      send_item(sample_item(0, 0, 0, 0, 1, 16'sd100, -16'sd32768));

      // Receiver holds off while ticks keep coming, so the input backs up.
      set_config(jpt_pkg::MODE_BUTTONS, 0, 0, 0, 0, 0, jpt_pkg::ANGLE_RESET,
                 jpt_pkg::ANGLE_RESET);
      send_item(sample_item(1, 0, 0, 1, 0, 0, 0));
      hold_request = 1;
      repeat (40) send_item(tick_item());

      for (int ph = 0; ph < 14; ph++) begin
         if (ph == 13) begin
            sender_gaps = 0;
            receiver_gaps = 0;
         end
         random_config();
         run_random_phase(35);
      end

      settle();
      if (model.pending_angles.size() > 0) begin
         model.error_count++;
         $display("%0t: %0d expected items never arrived", $time,
                  model.pending_angles.size());
      end
      repeat (5) @(posedge clock);
      $display("Covered %0d input items and %0d angle results over %0d register settings.",
               model.item_count, model.checked_count, config_count);
      $display("The input was held back for %0d cycles; %0d mismatches seen.",
               input_stall_cycles, model.error_count);
      if (model.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
